>>> rtl/core/tgce_pkg.sv
// Shared types, command codes and constants of the tilt gesture command encoder.
package tgce_pkg;

	localparam int STEP_W = 5;
	localparam int REG_IDX_W = 3;
	localparam int Z_W = 27;
	localparam logic signed [Z_W-1:0] Z_180 = 27'sd11796480;
	localparam logic [19:0] ONE_MILLION = 20'd1000000;

	localparam logic [7:0] ZONE_NONE = 8'h00;
	localparam logic [7:0] ZONE_FWD = 8'h10;
	localparam logic [7:0] ZONE_BACK = 8'h30;
	localparam logic [7:0] ZONE_FWD_HARD = 8'h18;
	localparam logic [7:0] ZONE_BACK_HARD = 8'h38;
	localparam logic [7:0] FLAG_LEFT = 8'h40;
	localparam logic [7:0] FLAG_RIGHT = 8'h80;
	localparam logic [7:0] FLAG_BUMP = 8'h01;
	localparam logic [7:0] HELD_RESET = 8'h38;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BLEND = 3'd0,
		REG_SENS = 3'd1,
		REG_DEAD = 3'd2,
		REG_TILT = 3'd3,
		REG_ROLL = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] blend_weight;
		logic [9:0] gyro_sensitivity;
		logic [7:0] dead_zone_deg;
		logic [7:0] tilt_limit_deg;
		logic [7:0] roll_trigger_deg;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CINIT,
		OP_CSTEP,
		OP_CEND,
		OP_MUL,
		OP_DINIT,
		OP_DSTEP,
		OP_SUM,
		OP_MIXA,
		OP_MIXB,
		OP_FIN,
		OP_ENC,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic axis;
		logic [STEP_W-1:0] step;
	} ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CINIT,
		ST_CSTEP,
		ST_CEND,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_SUM,
		ST_MIXA,
		ST_MIXB,
		ST_FIN,
		ST_ENC,
		ST_OUT
	} state_t;

	// atan(2^-i) in Q16 degrees
	function automatic logic [22:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [22:0] r;
		case (i)
			5'd0: r = 23'd2949120;
			5'd1: r = 23'd1740967;
			5'd2: r = 23'd919879;
			5'd3: r = 23'd466945;
			5'd4: r = 23'd234379;
			5'd5: r = 23'd117266;
			5'd6: r = 23'd58666;
			5'd7: r = 23'd29335;
			5'd8: r = 23'd14668;
			5'd9: r = 23'd7334;
			5'd10: r = 23'd3667;
			5'd11: r = 23'd1833;
			5'd12: r = 23'd917;
			5'd13: r = 23'd458;
			5'd14: r = 23'd229;
			5'd15: r = 23'd115;
			5'd16: r = 23'd57;
			5'd17: r = 23'd29;
			5'd18: r = 23'd14;
			5'd19: r = 23'd7;
			5'd20: r = 23'd4;
			5'd21: r = 23'd2;
			5'd22: r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/tgce_if.sv
// Sample and result channel interfaces.
interface tgce_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] acc_x;
	logic signed [15:0] acc_y;
	logic signed [15:0] acc_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic [15:0] elapsed_us;
	logic left_pin;
	logic right_pin;
	logic bump_pin;
	modport source(output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, elapsed_us,
		left_pin, right_pin, bump_pin, input ready);
	modport sink(input valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, elapsed_us,
		left_pin, right_pin, bump_pin, output ready);
endinterface

interface tgce_result_if;
	logic valid;
	logic ready;
	logic [7:0] command_byte;
	logic signed [15:0] angle_x_out;
	logic signed [15:0] angle_y_out;
	modport source(output valid, command_byte, angle_x_out, angle_y_out, input ready);
	modport sink(input valid, command_byte, angle_x_out, angle_y_out, output ready);
endinterface

>>> rtl/core/tgce_regs.sv
// APB configuration register file.
module tgce_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output tgce_pkg::cfg_t cfg
);
	tgce_pkg::cfg_t cfg_q;
	tgce_pkg::reg_idx_t idx;

	assign idx = tgce_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend_weight <= 16'd64881;
			cfg_q.gyro_sensitivity <= 10'd131;
			cfg_q.dead_zone_deg <= 8'd30;
			cfg_q.tilt_limit_deg <= 8'd60;
			cfg_q.roll_trigger_deg <= 8'd60;
		end else if (psel && penable && pwrite) begin
			case (idx)
				tgce_pkg::REG_BLEND: cfg_q.blend_weight <= pwdata[15:0];
				tgce_pkg::REG_SENS: cfg_q.gyro_sensitivity <= pwdata[9:0];
				tgce_pkg::REG_DEAD: cfg_q.dead_zone_deg <= pwdata[7:0];
				tgce_pkg::REG_TILT: cfg_q.tilt_limit_deg <= pwdata[7:0];
				tgce_pkg::REG_ROLL: cfg_q.roll_trigger_deg <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tgce_pkg::REG_BLEND: prdata = {16'd0, cfg_q.blend_weight};
			tgce_pkg::REG_SENS: prdata = {22'd0, cfg_q.gyro_sensitivity};
			tgce_pkg::REG_DEAD: prdata = {24'd0, cfg_q.dead_zone_deg};
			tgce_pkg::REG_TILT: prdata = {24'd0, cfg_q.tilt_limit_deg};
			tgce_pkg::REG_ROLL: prdata = {24'd0, cfg_q.roll_trigger_deg};
			default: prdata = 32'd0;
		endcase
	end
endmodule

>>> rtl/core/tgce_ctrl.sv
// Sequencing state machine: CORDIC passes, blend steps, encode and result hand-off.
module tgce_ctrl #(
	parameter int CORDIC_STEPS = 16,
	parameter int DIV_STEPS = 21
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic res_valid,
	input logic res_ready,
	output tgce_pkg::ctl_t ctl
);
	tgce_pkg::state_t st_q, st_n;
	logic [tgce_pkg::STEP_W-1:0] cnt_q;
	logic axis_q;
	logic res_valid_q;
	logic publish;
	logic in_fire;

	assign in_ready = (st_q == tgce_pkg::ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign publish = (st_q == tgce_pkg::ST_OUT) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;

	always_comb begin
		st_n = st_q;
		case (st_q)
			tgce_pkg::ST_IDLE: if (in_valid) st_n = tgce_pkg::ST_CINIT;
			tgce_pkg::ST_CINIT: st_n = tgce_pkg::ST_CSTEP;
			tgce_pkg::ST_CSTEP:
				if (cnt_q == tgce_pkg::STEP_W'(CORDIC_STEPS - 1)) st_n = tgce_pkg::ST_CEND;
			tgce_pkg::ST_CEND: st_n = axis_q ? tgce_pkg::ST_MUL : tgce_pkg::ST_CINIT;
			tgce_pkg::ST_MUL: st_n = tgce_pkg::ST_DINIT;
			tgce_pkg::ST_DINIT: st_n = tgce_pkg::ST_DIV;
			tgce_pkg::ST_DIV:
				if (cnt_q == tgce_pkg::STEP_W'(DIV_STEPS - 1)) st_n = tgce_pkg::ST_SUM;
			tgce_pkg::ST_SUM: st_n = tgce_pkg::ST_MIXA;
			tgce_pkg::ST_MIXA: st_n = tgce_pkg::ST_MIXB;
			tgce_pkg::ST_MIXB: st_n = tgce_pkg::ST_FIN;
			tgce_pkg::ST_FIN: st_n = axis_q ? tgce_pkg::ST_ENC : tgce_pkg::ST_MUL;
			tgce_pkg::ST_ENC: st_n = tgce_pkg::ST_OUT;
			tgce_pkg::ST_OUT: if (publish) st_n = tgce_pkg::ST_IDLE;
			default: st_n = tgce_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.axis = axis_q;
		ctl.step = cnt_q;
		case (st_q)
			tgce_pkg::ST_IDLE: ctl.op = in_valid ? tgce_pkg::OP_LOAD : tgce_pkg::OP_NONE;
			tgce_pkg::ST_CINIT: ctl.op = tgce_pkg::OP_CINIT;
			tgce_pkg::ST_CSTEP: ctl.op = tgce_pkg::OP_CSTEP;
			tgce_pkg::ST_CEND: ctl.op = tgce_pkg::OP_CEND;
			tgce_pkg::ST_MUL: ctl.op = tgce_pkg::OP_MUL;
			tgce_pkg::ST_DINIT: ctl.op = tgce_pkg::OP_DINIT;
			tgce_pkg::ST_DIV: ctl.op = tgce_pkg::OP_DSTEP;
			tgce_pkg::ST_SUM: ctl.op = tgce_pkg::OP_SUM;
			tgce_pkg::ST_MIXA: ctl.op = tgce_pkg::OP_MIXA;
			tgce_pkg::ST_MIXB: ctl.op = tgce_pkg::OP_MIXB;
			tgce_pkg::ST_FIN: ctl.op = tgce_pkg::OP_FIN;
			tgce_pkg::ST_ENC: ctl.op = tgce_pkg::OP_ENC;
			tgce_pkg::ST_OUT: ctl.op = publish ? tgce_pkg::OP_PUBLISH : tgce_pkg::OP_NONE;
			default: ctl.op = tgce_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tgce_pkg::ST_IDLE;
			cnt_q <= '0;
			axis_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if ((st_q == tgce_pkg::ST_CSTEP || st_q == tgce_pkg::ST_DIV) && st_n == st_q)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (st_q == tgce_pkg::ST_CEND || st_q == tgce_pkg::ST_FIN)
				axis_q <= !axis_q;
			if (publish)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> st_q == tgce_pkg::ST_CINIT)
		else $error("accepted request did not start the roll CORDIC pass");
	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == tgce_pkg::ST_CSTEP |-> cnt_q < tgce_pkg::STEP_W'(CORDIC_STEPS))
		else $error("CORDIC iteration count overran");
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(st_q == tgce_pkg::ST_OUT))
		else $error("result raised outside the hand-off state");
endmodule

>>> rtl/core/tgce_dp.sv
// Datapath: shared CORDIC vectoring unit, serial divider, blend multiplies and encoder.
module tgce_dp #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int DIV_STEPS = 21
) (
	input logic clk,
	input logic arst_n,
	input tgce_pkg::ctl_t ctl,
	input tgce_pkg::cfg_t cfg,
	input logic signed [15:0] acc_x,
	input logic signed [15:0] acc_y,
	input logic signed [15:0] acc_z,
	input logic signed [15:0] gyro_x,
	input logic signed [15:0] gyro_y,
	input logic [15:0] elapsed_us,
	input logic left_pin,
	input logic right_pin,
	input logic bump_pin,
	output logic [7:0] command_byte,
	output logic signed [15:0] angle_x_out,
	output logic signed [15:0] angle_y_out
);
	localparam int F = ANGLE_FRAC_BITS;
	localparam int XY_W = 36;
	localparam int DEN_W = 30;
	localparam int DIV_W = DEN_W + DIV_STEPS;
	localparam int SUM_W = DIV_STEPS + 2;
	localparam int ACC_W = F + 11;
	localparam int MIX_W = SUM_W + 19;
	localparam int TH_W = F + 10;
	localparam int Z_W = tgce_pkg::Z_W;

	// sample registers
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic [15:0] dt_q;
	logic bump_q;
	// state
	logic signed [15:0] roll_q, pitch_q;
	logic left_q, right_q;
	logic [7:0] held_q;
	// CORDIC
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic zero_q;
	logic signed [ACC_W-1:0] acc_roll_q, acc_pitch_q;
	// blend
	logic signed [32:0] gd_q;
	logic [DEN_W-1:0] den_q;
	logic neg_q;
	logic [DIV_W-1:0] rem_q, dsr_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [MIX_W-1:0] mixa_q, mixb_q;
	logic [7:0] cmd_q;
	logic [7:0] res_cmd_q;
	logic signed [15:0] res_ax_q, res_ay_q;

	logic left_n, right_n;
	logic signed [16:0] ci_x, ci_y, cx, cy;
	logic ci_zero;
	logic signed [Z_W-1:0] ci_z;
	logic signed [XY_W-1:0] xs, ys;
	logic signed [Z_W-1:0] at;
	logic signed [Z_W-1:0] z_rnd;
	logic [9:0] sens_eff;
	logic [32:0] mag;
	logic ge;
	logic signed [15:0] ang_sel;
	logic signed [ACC_W-1:0] acc_sel;
	logic [16:0] wc;
	logic signed [MIX_W-1:0] mix_t, mix_r;
	logic signed [15:0] sat;
	logic signed [TH_W-1:0] pe, rx, dz, tl, tr;
	logic [7:0] zone, cmd_n, held_n;

	assign left_n = right_q ? left_q : left_pin;
	assign right_n = left_n ? right_q : right_pin;

	// CORDIC pre-rotation into the right half plane
	always_comb begin
		ci_x = {az_q[15], az_q};
		ci_y = ctl.axis ? -{ax_q[15], ax_q} : {ay_q[15], ay_q};
		ci_zero = (ci_x == '0) && (ci_y == '0);
		if (ci_x < 0) begin
			ci_z = (ci_y >= 0) ? tgce_pkg::Z_180 : -tgce_pkg::Z_180;
			cx = -ci_x;
			cy = -ci_y;
		end else begin
			ci_z = '0;
			cx = ci_x;
			cy = ci_y;
		end
	end

	assign xs = x_q >>> ctl.step;
	assign ys = y_q >>> ctl.step;
	assign at = Z_W'(tgce_pkg::atan_q16(ctl.step));
	assign z_rnd = (z_q + (Z_W'(1) <<< (15 - F))) >>> (16 - F);

	assign sens_eff = (cfg.gyro_sensitivity == '0) ? 10'd1 : cfg.gyro_sensitivity;
	assign mag = gd_q[32] ? 33'(-gd_q) : 33'(gd_q);
	assign ge = rem_q >= dsr_q;
	assign ang_sel = ctl.axis ? pitch_q : roll_q;
	assign acc_sel = ctl.axis ? acc_pitch_q : acc_roll_q;
	assign wc = 17'(17'd65536 - {1'b0, cfg.blend_weight});
	assign mix_t = mixa_q + mixb_q + MIX_W'(32768);
	assign mix_r = mix_t >>> 16;
	always_comb begin
		if (mix_r > MIX_W'(32767)) sat = 16'sh7fff;
		else if (mix_r < -MIX_W'(32768)) sat = -16'sh8000;
		else sat = mix_r[15:0];
	end

	// command encoder
	always_comb begin
		pe = TH_W'(pitch_q);
		rx = TH_W'(roll_q);
		dz = TH_W'({cfg.dead_zone_deg, F'(0)});
		tl = TH_W'({cfg.tilt_limit_deg, F'(0)});
		tr = TH_W'({cfg.roll_trigger_deg, F'(0)});
		if (pe >= -dz && pe <= dz) zone = tgce_pkg::ZONE_NONE;
		else if (pe > dz && pe <= tl) zone = tgce_pkg::ZONE_FWD;
		else if (pe < -dz && pe >= -tl) zone = tgce_pkg::ZONE_BACK;
		else if (pe > tl) zone = tgce_pkg::ZONE_FWD_HARD;
		else zone = tgce_pkg::ZONE_BACK_HARD;
		held_n = held_q;
		if (rx > tr || rx < -tr) begin
			// held byte follows each flag added before the last
			cmd_n = held_q;
			if (left_q && cmd_n != 8'd0) begin
				held_n = cmd_n;
				cmd_n = cmd_n | tgce_pkg::FLAG_LEFT;
			end
			if (right_q && cmd_n != 8'd0) begin
				held_n = cmd_n;
				cmd_n = cmd_n | tgce_pkg::FLAG_RIGHT;
			end
			if (bump_q) begin
				held_n = cmd_n;
				cmd_n = cmd_n | tgce_pkg::FLAG_BUMP;
			end
		end else begin
			cmd_n = zone;
			if (left_q && cmd_n != 8'd0) cmd_n = cmd_n | tgce_pkg::FLAG_LEFT;
			if (right_q && cmd_n != 8'd0) cmd_n = cmd_n | tgce_pkg::FLAG_RIGHT;
			if (bump_q) cmd_n = cmd_n | tgce_pkg::FLAG_BUMP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q <= '0;
			pitch_q <= '0;
			left_q <= 1'b0;
			right_q <= 1'b0;
			held_q <= tgce_pkg::HELD_RESET;
		end else begin
			case (ctl.op)
				tgce_pkg::OP_LOAD: begin
					left_q <= left_n;
					right_q <= right_n;
				end
				tgce_pkg::OP_FIN: begin
					if (ctl.axis) pitch_q <= sat;
					else roll_q <= sat;
				end
				tgce_pkg::OP_ENC: held_q <= held_n;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			tgce_pkg::OP_LOAD: begin
				ax_q <= acc_x;
				ay_q <= acc_y;
				az_q <= acc_z;
				gx_q <= gyro_x;
				gy_q <= gyro_y;
				dt_q <= elapsed_us;
				bump_q <= bump_pin;
			end
			tgce_pkg::OP_CINIT: begin
				x_q <= XY_W'(cx) <<< 16;
				y_q <= XY_W'(cy) <<< 16;
				z_q <= ci_z;
				zero_q <= ci_zero;
			end
			tgce_pkg::OP_CSTEP: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			tgce_pkg::OP_CEND: begin
				if (ctl.axis) acc_pitch_q <= zero_q ? '0 : z_rnd[ACC_W-1:0];
				else acc_roll_q <= zero_q ? '0 : z_rnd[ACC_W-1:0];
			end
			tgce_pkg::OP_MUL: begin
				gd_q <= 33'(ctl.axis ? gy_q : gx_q) * 33'($signed({1'b0, dt_q}));
				den_q <= DEN_W'(sens_eff) * DEN_W'(tgce_pkg::ONE_MILLION);
			end
			tgce_pkg::OP_DINIT: begin
				neg_q <= gd_q[32];
				rem_q <= (DIV_W'(mag) << F) + DIV_W'(den_q >> 1);
				dsr_q <= DIV_W'(den_q) << (DIV_STEPS - 1);
				quo_q <= '0;
			end
			tgce_pkg::OP_DSTEP: begin
				if (ge) rem_q <= rem_q - dsr_q;
				dsr_q <= dsr_q >> 1;
				quo_q <= {quo_q[DIV_STEPS-2:0], ge};
			end
			tgce_pkg::OP_SUM: begin
				if (neg_q) sum_q <= SUM_W'(ang_sel) - $signed({2'b00, quo_q});
				else sum_q <= SUM_W'(ang_sel) + $signed({2'b00, quo_q});
			end
			tgce_pkg::OP_MIXA:
				mixa_q <= MIX_W'($signed({1'b0, cfg.blend_weight})) * MIX_W'(sum_q);
			tgce_pkg::OP_MIXB: mixb_q <= MIX_W'($signed({1'b0, wc})) * MIX_W'(acc_sel);
			tgce_pkg::OP_ENC: cmd_q <= cmd_n;
			tgce_pkg::OP_PUBLISH: begin
				res_cmd_q <= cmd_q;
				res_ax_q <= roll_q;
				res_ay_q <= pitch_q;
			end
			default: ;
		endcase
	end

	assign command_byte = res_cmd_q;
	assign angle_x_out = res_ax_q;
	assign angle_y_out = res_ay_q;

	a_latch_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(left_q && right_q))
		else $error("left and right latches both set");
	a_quo_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == tgce_pkg::OP_DINIT |=> rem_q < (dsr_q << 1))
		else $error("gyro increment quotient exceeds divider width");
	a_held_in_enc: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(held_q) |-> $past(ctl.op == tgce_pkg::OP_ENC))
		else $error("held byte changed outside encode");
endmodule

>>> rtl/core/tilt_gesture_command_encoder_core.sv
// Tilt gesture command encoder top level.
// One sample is taken when the block is idle and yields one result: command byte and the
// filtered roll and pitch angles. Processing runs the single CORDIC vectoring unit twice
// per sample and the one-bit-per-cycle divider once per axis for the gyro increment.
// A finished result sits in an output register, so the next sample is accepted while
// it waits to be taken. Configure over APB only while idle.
module tilt_gesture_command_encoder_core #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	tgce_sample_if.sink sample,
	tgce_result_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int DIV_STEPS = ANGLE_FRAC_BITS + 14;

	tgce_pkg::cfg_t cfg;
	tgce_pkg::ctl_t ctl;

	tgce_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	tgce_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.DIV_STEPS(DIV_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample.valid),
		.in_ready(sample.ready),
		.res_valid(result.valid),
		.res_ready(result.ready),
		.ctl(ctl)
	);

	tgce_dp #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.DIV_STEPS(DIV_STEPS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.cfg(cfg),
		.acc_x(sample.acc_x),
		.acc_y(sample.acc_y),
		.acc_z(sample.acc_z),
		.gyro_x(sample.gyro_x),
		.gyro_y(sample.gyro_y),
		.elapsed_us(sample.elapsed_us),
		.left_pin(sample.left_pin),
		.right_pin(sample.right_pin),
		.bump_pin(sample.bump_pin),
		.command_byte(result.command_byte),
		.angle_x_out(result.angle_x_out),
		.angle_y_out(result.angle_y_out)
	);
endmodule
